// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file fap_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fap_pkg.sv =====
// Shared types and constants of the FASTA alignment parser.
// No dependencies; imported by every design module.
package fap_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ALIGN_W  = 24;
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 3;
    localparam int KIND_W   = 2;
    localparam int M_TDATA_W = 56;

    localparam logic [BYTE_W-1:0] CHAR_GT   = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;  // newline
    localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2D;  // '-'

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 2'd0,
        KIND_NAME_CHR = 2'd1,
        KIND_NAME_END = 2'd2,
        KIND_BASE     = 2'd3
    } fap_kind_t;

    localparam logic [CODE_W-1:0] BASE_T     = 3'd1;
    localparam logic [CODE_W-1:0] BASE_C     = 3'd2;
    localparam logic [CODE_W-1:0] BASE_G     = 3'd3;
    localparam logic [CODE_W-1:0] BASE_A     = 3'd4;
    localparam logic [CODE_W-1:0] BASE_OTHER = 3'd5;
    localparam logic [CODE_W-1:0] BASE_GAP   = 3'd6;
    localparam logic [CODE_W-1:0] BASE_ZERO  = 3'd0;

    typedef struct packed {
        fap_kind_t             kind;
        logic [CODE_W-1:0]     base_code;
        logic [BYTE_W-1:0]     name_char;
        logic [SAMPLE_W-1:0]   sample_count;
        logic [ALIGN_W-1:0]    alignment_length;
        logic                  length_error;
        logic                  done_res;
    } fap_result_t;

    function automatic logic [CODE_W-1:0] map_base(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] code;
        case (b)
            8'h54, 8'h74: code = BASE_T;
            8'h43, 8'h63: code = BASE_C;
            8'h47, 8'h67: code = BASE_G;
            8'h41, 8'h61: code = BASE_A;
            CHAR_DASH:    code = BASE_GAP;
            default:      code = BASE_OTHER;
        endcase
        return code;
    endfunction

endpackage

// ===== design/fap_parse_core.sv =====
// Parse state and per-byte next-state/result logic.
// Depends on fap_pkg.
module fap_parse_core import fap_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    output fap_result_t       result
);

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_HEAD = 2'd1,
        PH_SEQ  = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_mid;
    logic [LENGTH_BITS-1:0] ref_len_reg, ref_len_next, ref_len_mid;
    logic                   ref_known_reg, ref_known_next, ref_known_mid;
    logic [LENGTH_BITS-1:0] rec_len_reg, rec_len_next, rec_len_mid;
    logic [COUNT_BITS-1:0]  samples_reg, samples_next, samples_mid;
    logic                   mismatch_reg, mismatch_next, mismatch_mid;
    logic                   close_rec;
    fap_kind_t              kind;
    logic [CODE_W-1:0]      code;
    logic [BYTE_W-1:0]      ch;

    always_comb begin
        phase_mid   = phase_reg;
        rec_len_mid = rec_len_reg;
        samples_mid = samples_reg;
        close_rec   = 1'b0;
        kind        = KIND_NONE;
        code        = BASE_ZERO;
        ch          = '0;
        unique case (phase_reg)
            PH_HEAD: begin
                if (data_byte == CHAR_NL) begin
                    rec_len_mid = '0;
                    if (samples_reg != '1)
                        samples_mid = samples_reg + COUNT_BITS'(1);
                    phase_mid = PH_SEQ;
                    kind      = KIND_NAME_END;
                end else if (data_byte != CHAR_GT) begin
                    kind = KIND_NAME_CHR;
                    ch   = data_byte;
                end
            end
            PH_SEQ: begin
                if (data_byte == CHAR_GT) begin
                    close_rec = 1'b1;
                    phase_mid = PH_HEAD;
                end else if (data_byte != CHAR_NL) begin
                    if (rec_len_reg != '1)
                        rec_len_mid = rec_len_reg + LENGTH_BITS'(1);
                    kind = KIND_BASE;
                    code = map_base(data_byte);
                end
            end
            default: begin
                // Seeking, and the unused phase code behaves the same.
                phase_mid = (data_byte == CHAR_GT) ? PH_HEAD : PH_SEEK;
            end
        endcase

        // Close the final record on the last byte if still in a sequence.
        if (last_byte && phase_mid == PH_SEQ)
            close_rec = 1'b1;

        ref_len_mid   = ref_len_reg;
        ref_known_mid = ref_known_reg;
        mismatch_mid  = mismatch_reg;
        if (close_rec) begin
            if (!ref_known_reg) begin
                ref_len_mid   = rec_len_mid;
                ref_known_mid = 1'b1;
            end else if (ref_len_reg != rec_len_mid) begin
                mismatch_mid = 1'b1;
            end
        end

        result.kind             = kind;
        result.base_code        = code;
        result.name_char        = ch;
        result.sample_count     = SAMPLE_W'(samples_mid);
        result.alignment_length = ref_known_mid ? ALIGN_W'(ref_len_mid) : '0;
        result.length_error     = mismatch_mid;
        result.done_res         = last_byte;

        // Start a fresh file after the last byte.
        if (last_byte) begin
            phase_next     = PH_SEEK;
            ref_len_next   = '0;
            ref_known_next = 1'b0;
            rec_len_next   = '0;
            samples_next   = '0;
            mismatch_next  = 1'b0;
        end else begin
            phase_next     = phase_mid;
            ref_len_next   = ref_len_mid;
            ref_known_next = ref_known_mid;
            rec_len_next   = rec_len_mid;
            samples_next   = samples_mid;
            mismatch_next  = mismatch_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            ref_len_reg   <= '0;
            ref_known_reg <= 1'b0;
            rec_len_reg   <= '0;
            samples_reg   <= '0;
            mismatch_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            ref_len_reg   <= ref_len_next;
            ref_known_reg <= ref_known_next;
            rec_len_reg   <= rec_len_next;
            samples_reg   <= samples_next;
            mismatch_reg  <= mismatch_next;
        end
    end

endmodule

// ===== design/fap_out_stage.sv =====
// Result register of the parser with its output handshake.
// Depends on fap_pkg.
module fap_out_stage import fap_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  fap_result_t     result,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // base_code, name_char, sample_count,
                                            // alignment_length, length_error, zero pad
    output logic [KIND_W-1:0]    m_tuser,   // kind
    output logic                 m_tlast    // done_res
);

    fap_result_t res_reg;
    logic        valid_reg, valid_next;

    // Take a new request when empty or when the current one leaves now.
    assign free = !valid_reg || m_tready;

    always_comb begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load)
            res_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.done_res;
    assign m_tdata  = {4'b0000, res_reg.length_error, res_reg.alignment_length,
                       res_reg.sample_count, res_reg.name_char, res_reg.base_code};

endmodule

// ===== design/fasta_alignment_parser_unit.sv =====
// FASTA alignment parser: top level with input register, parse core and result stage.
// Depends on fap_pkg, fap_parse_core and fap_out_stage.
//
// Usage:
//   The input channel (s_) takes one raw byte of a FASTA alignment per request
//   in s_tdata, with s_tlast high on the final byte of the file. The result
//   channel (m_) returns exactly one request per input byte, in order: kind in
//   m_tuser, done flag in m_tlast, and base code, name character, sample count,
//   alignment length and sticky length error packed in m_tdata.
//   A byte that is taken lands in the input register, is parsed there by
//   combinational logic and is loaded into the result register, which drives
//   m_; m_tvalid rises when that register is loaded. Throughput: one byte per
//   cycle while m_tready stays high, since the parse step between the input
//   register and the result register is combinational.
//   Stalls: while m_tready is low the result holds; one more byte may wait in
//   the input register, after which s_tready drops until the result leaves.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to seeking the first header with all counts cleared. After the
//   result for a last byte the parser clears itself and starts a new file.
module fasta_alignment_parser_unit import fap_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // data_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // base_code[2:0], name_char[10:3],
                                             // sample_count[26:11],
                                             // alignment_length[50:27],
                                             // length_error[51], zero[55:52]
    output logic [KIND_W-1:0]     m_tuser,   // kind
    output logic                  m_tlast    // done_res
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              out_free;
    logic              advance;
    fap_result_t       result;

    // Move the held byte into the result stage whenever that stage can take it.
    assign advance  = in_valid_reg && out_free;
    // Accept a new byte when the input register is empty or drains this cycle.
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Payload: capture only on accept, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    // Parse state advances once per byte, together with the result load.
    fap_parse_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .result    (result)
    );

    fap_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/fap_checker.sv =====
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on fap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fap_checker import fap_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser
);

    `ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ASSERT_CLK(a_code_only_base, aclk, aresetn, m_tvalid && m_tuser != KIND_BASE |-> m_tdata[2:0] == BASE_ZERO, "base code set outside a base result")
    `ASSERT_CLK(a_code_range, aclk, aresetn, m_tvalid && m_tuser == KIND_BASE |-> m_tdata[2:0] != BASE_ZERO && m_tdata[2:0] != 3'd7, "base code out of range")
    `ASSERT_CLK(a_char_only_name, aclk, aresetn, m_tvalid && m_tuser != KIND_NAME_CHR |-> m_tdata[10:3] == 8'h00, "name character set outside a name result")

endmodule

bind fasta_alignment_parser_unit fap_checker u_fap_checker (.*);

// ===== tb/sv/fap_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the FASTA alignment parser: watches both stream channels,
// predicts each parse result and compares it field by field. Depends on fap_pkg.
module fap_result_checker import fap_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   mismatch_total,
    output int                   results_owed
);

    localparam logic [ALIGN_W-1:0]  LEN_SAT   = '1;
    localparam logic [SAMPLE_W-1:0] COUNT_SAT = '1;

    typedef enum logic [1:0] {
        SCAN_SEEK  = 2'd0,
        SCAN_NAME  = 2'd1,
        SCAN_BASES = 2'd2
    } scan_phase_t;

    scan_phase_t         phase;
    logic [ALIGN_W-1:0]  first_len;
    logic                first_len_valid;
    logic [ALIGN_W-1:0]  cur_len;
    logic [SAMPLE_W-1:0] names_done;
    logic                len_mismatch;

    fap_result_t parsed_results_q[$];

    function automatic void clear_parse_state();
        phase           = SCAN_SEEK;
        first_len       = '0;
        first_len_valid = 1'b0;
        cur_len         = '0;
        names_done      = '0;
        len_mismatch    = 1'b0;
    endfunction

    // The first closed record sets the alignment length; later ones must match it.
    function automatic void close_record();
        if (!first_len_valid) begin
            first_len       = cur_len;
            first_len_valid = 1'b1;
        end else if (first_len != cur_len) begin
            len_mismatch = 1'b1;
        end
    endfunction

    function automatic fap_result_t parse_next_byte(input logic [BYTE_W-1:0] b,
                                                    input logic last);
        fap_result_t r;
        r = '0;
        case (phase)
            SCAN_NAME: begin
                if (b == CHAR_NL) begin
                    cur_len = '0;
                    if (names_done != COUNT_SAT)
                        names_done++;
                    phase  = SCAN_BASES;
                    r.kind = KIND_NAME_END;
                end else if (b != CHAR_GT) begin
                    r.kind      = KIND_NAME_CHR;
                    r.name_char = b;
                end
            end
            SCAN_BASES: begin
                if (b == CHAR_GT) begin
                    close_record();
                    phase = SCAN_NAME;
                end else if (b != CHAR_NL) begin
                    if (cur_len != LEN_SAT)
                        cur_len++;
                    r.kind = KIND_BASE;
                    case (b)
                        "T", "t":  r.base_code = BASE_T;
                        "C", "c":  r.base_code = BASE_C;
                        "G", "g":  r.base_code = BASE_G;
                        "A", "a":  r.base_code = BASE_A;
                        CHAR_DASH: r.base_code = BASE_GAP;
                        default:   r.base_code = BASE_OTHER;
                    endcase
                end
            end
            default: phase = (b == CHAR_GT) ? SCAN_NAME : SCAN_SEEK;
        endcase

        // the final record of a file is closed on its last byte
        if (last && phase == SCAN_BASES)
            close_record();

        r.sample_count     = names_done;
        r.alignment_length = first_len_valid ? first_len : '0;
        r.length_error     = len_mismatch;
        r.done_res         = last;
        if (last)
            clear_parse_state();
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
        end
    endtask

    initial begin
        mismatch_total = 0;
        results_owed   = 0;
        clear_parse_state();
    end

    always @(posedge aclk) begin : watch_channels
        fap_result_t want;
        if (!aresetn) begin
            clear_parse_state();
            parsed_results_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                parsed_results_q.push_back(parse_next_byte(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                if (parsed_results_q.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = parsed_results_q.pop_front();
                    check_field("kind",             want.kind,             m_tuser);
                    check_field("base_code",        want.base_code,        m_tdata[2:0]);
                    check_field("name_char",        want.name_char,        m_tdata[10:3]);
                    check_field("sample_count",     want.sample_count,     m_tdata[26:11]);
                    check_field("alignment_length", want.alignment_length, m_tdata[50:27]);
                    check_field("length_error",     want.length_error,     m_tdata[51]);
                    check_field("tdata padding",    '0, m_tdata[M_TDATA_W-1:52]);
                    check_field("done_res",         want.done_res,         m_tlast);
                end
            end
        end
        results_owed = parsed_results_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the FASTA alignment parser testbench: clock, reset, byte stimulus,
// result back-pressure and verdict. Depends on fap_pkg, the parser and fap_result_checker.
module testbench;
    import fap_pkg::*;

    // Run bounds.
    localparam int CYCLE_LIMIT   = 100_000;
    localparam int DRAIN_CYCLES  = 8;      // margin after the last result is checked
    localparam int BYTES_PER_MODE = 500;   // random bytes under each idling mode
    localparam int HOLD_AFTER    = 300;    // results taken before the long stall
    localparam int HOLD_CYCLES   = 80;     // length of the long stall

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    int mismatch_total;
    int results_owed;
    int cycle_count = 0;
    int bytes_sent  = 0;

    // Idle rates in percent, changed by the stimulus between phases.
    int src_idle_pct = 12;
    int snk_idle_pct = 55;

    logic [BYTE_W-1:0] file_bytes[$];
    string             base_letters = "ACGTacgt-";

    fasta_alignment_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    fap_result_checker u_result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_total (mismatch_total),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: give up on a hung block.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Result side: drop m_tready at random per the current idle rate, and once,
    // after HOLD_AFTER results, hold it low for a long stretch so the parser's
    // registers fill and s_tready drops while the sender keeps offering.
    initial begin : result_sink
        int taken;
        int hold_left;
        bit held_once;
        taken     = 0;
        hold_left = 0;
        held_once = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_once && taken >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offer one byte as a request; idle first at the sender's rate, then hold
    // the request until it is taken. s_tready read right after the edge is the
    // value the handshake used.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // Mostly nucleotide letters and gaps, sometimes other symbols or high bytes.
    function automatic logic [BYTE_W-1:0] pick_base();
        int roll;
        logic [BYTE_W-1:0] c;
        roll = $urandom_range(99);
        if (roll < 80)
            c = base_letters[$urandom_range(base_letters.len() - 1)];
        else if (roll < 90)
            c = 8'($urandom_range(128, 255));
        else
            c = 8'($urandom_range(255));
        // keep the record open: a newline or '>' here would change the shape
        if (c == CHAR_NL || c == CHAR_GT)
            c = "N";
        return c;
    endfunction

    // Printable names most of the time, any byte but newline otherwise.
    function automatic logic [BYTE_W-1:0] pick_name_char();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(9) < 8)
            c = 8'($urandom_range(33, 126));
        else
            c = 8'($urandom_range(255));
        // a '>' inside a name is dropped by the parser; use it instead of newline
        if (c == CHAR_NL)
            c = CHAR_GT;
        return c;
    endfunction

    // Build one alignment file into file_bytes: optional junk before the first
    // header, then a few records of mostly equal length with wrapped sequence
    // lines. About one file in eight is cut short at a random byte.
    task automatic build_fasta_file();
        int n_rec;
        int width;
        int w;
        int wrap;
        int cut;
        file_bytes.delete();
        repeat ($urandom_range(0, 2))
            file_bytes.push_back(8'($urandom_range(255)));
        n_rec = $urandom_range(1, 5);
        width = $urandom_range(0, 24);
        for (int r = 0; r < n_rec; r++) begin
            w    = ($urandom_range(99) < 80) ? width : $urandom_range(0, 24);
            wrap = $urandom_range(4, 16);
            file_bytes.push_back(CHAR_GT);
            repeat ($urandom_range(1, 8))
                file_bytes.push_back(pick_name_char());
            file_bytes.push_back(CHAR_NL);
            for (int i = 0; i < w; i++) begin
                file_bytes.push_back(pick_base());
                if ((i + 1) % wrap == 0)
                    file_bytes.push_back(CHAR_NL);
            end
            if ($urandom_range(1))
                file_bytes.push_back(CHAR_NL);
        end
        if ($urandom_range(7) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endtask

    // Send file_bytes, marking the final byte with tlast.
    task automatic send_file();
        foreach (file_bytes[i])
            push_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Mostly whole files with random content; the rest is bursts of raw noise
    // with a rare tlast, which also leaves the parser mid-file at times.
    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                build_fasta_file();
                send_file();
            end else begin
                repeat ($urandom_range(1, 12))
                    push_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
            end
        end
    endtask

    initial begin : stimulus
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed file: junk while seeking, '>' inside a name, extreme name
        // bytes, every base class, newline inside a sequence, then a second
        // record that is shorter and ends on the last byte (length error).
        push_byte("x", 1'b0);
        push_byte(CHAR_NL, 1'b0);
        push_byte(CHAR_GT, 1'b0);
        push_byte(CHAR_GT, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CHAR_NL, 1'b0);
        push_byte("A", 1'b0);
        push_byte("c", 1'b0);
        push_byte("G", 1'b0);
        push_byte("t", 1'b0);
        push_byte(CHAR_DASH, 1'b0);
        push_byte("N", 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(CHAR_NL, 1'b0);
        push_byte(CHAR_GT, 1'b0);
        push_byte("a", 1'b0);
        push_byte(CHAR_NL, 1'b0);
        push_byte("T", 1'b0);
        push_byte("G", 1'b1);
        // last byte in a header, then last byte while seeking
        push_byte(CHAR_GT, 1'b1);
        push_byte(8'h00, 1'b1);
        // empty first record sets length zero; empty last record matches it
        push_byte(CHAR_GT, 1'b0);
        push_byte(CHAR_NL, 1'b0);
        push_byte(CHAR_GT, 1'b0);
        push_byte(CHAR_NL, 1'b1);

        // Random part under three idling modes.
        run_random(BYTES_PER_MODE);
        src_idle_pct = 55;
        snk_idle_pct = 12;
        run_random(BYTES_PER_MODE);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(BYTES_PER_MODE);

        // Drop valid, let the checker log the final request, then drain.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/fap_pkg.sv
design/fap_parse_core.sv
design/fap_out_stage.sv
design/fasta_alignment_parser_unit.sv
design/fap_checker.sv
tb/sv/fap_result_checker.sv
tb/sv/testbench.sv
